// ----- rtl/bldq_pkg.sv -----
// ============================================================================
// bldq_pkg
// Shared types and defaults for the bounded deque with delete by key.
// ============================================================================
package bldq_pkg;

   // Default sizing of the list
   localparam int DEFAULT_CAPACITY   = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // Fixed field widths
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes carried by an item
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DELETE_KEY = 3'd4
   } action_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_NOKEY = 2'd3
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ----- rtl/bounded_list_deque_with_key_delete_unit.sv -----
// ============================================================================
// bounded_list_deque_with_key_delete_unit
// Bounded double-ended list held in a circular single-port-read memory, with
// push/pop at both ends and removal of the first entry equal to a key.
// ============================================================================
// Push, pop and spare action codes go from IDLE to FINISH, which loads the
// result register once it is free; the next item is taken back in IDLE.
// Delete by key: one memory read per entry scanned, then one per entry closed
// up, before FINISH loads the result. A stalled result holds FINISH and so
// holds off the next item.
// Reset clears front pointer, count and sequencer; the entry memory is not
// cleared and is only read inside the occupied range.
module bounded_list_deque_with_key_delete_unit #(
   parameter int CAPACITY   = bldq_pkg::DEFAULT_CAPACITY,
   parameter int DATA_WIDTH = bldq_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bldq_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bldq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bldq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_occupancy
);
   import bldq_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   // Entry memory and its registered read data
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Control and working registers
   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]      iss_off_ff, iss_off_in;
   logic [PTR_W-1:0]      iss_slot_ff, iss_slot_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]      cmp_off_ff, cmp_off_in;
   logic [PTR_W-1:0]      cmp_slot_ff, cmp_slot_in;
   logic [CNT_W-1:0]      dst_off_ff, dst_off_in;
   logic [PTR_W-1:0]      dst_slot_ff, dst_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;

   // Memory port controls
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic                  req_accept;
   logic                  out_free;
   logic [DATA_WIDTH-1:0] req_data;
   logic [SUM_W-1:0]      back_sum;
   logic [PTR_W-1:0]      back_slot;
   logic                  is_full;
   logic                  is_empty;
   logic                  matched;
   logic [CNT_W-1:0]      last_off;

   // Wrap helpers for the circular index
   function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
      return (s == PTR_W'(CAPACITY - 1)) ? '0 : PTR_W'(s + 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
      return (s == '0) ? PTR_W'(CAPACITY - 1) : PTR_W'(s - 1'b1);
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sign-extend or trim the incoming value to the stored width
   assign req_data = DATA_WIDTH'(req_value);

   // Slot just past the back entry; front and count both stay below CAPACITY here
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                      PTR_W'(back_sum - SUM_W'(CAPACITY)) : PTR_W'(back_sum);

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign matched  = cmp_vld_ff && (rd_data_ff == key_ff);
   assign last_off = CNT_W'(count_ff - 1'b1);

   // Sequence the operations
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      iss_off_in    = iss_off_ff;
      iss_slot_in   = iss_slot_ff;
      cmp_vld_in    = 1'b0;
      cmp_off_in    = cmp_off_ff;
      cmp_slot_in   = cmp_slot_ff;
      dst_off_in    = dst_off_ff;
      dst_slot_in   = dst_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      wr_data       = req_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in  = ST_FINISH;
               status_in = STATUS_OK;
               case (action_type'(req_action))
                  ACT_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        front_in = slot_prev(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = slot_prev(front_ff);
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_slot;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        front_in = slot_next(front_ff);
                        count_in = last_off;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = last_off;
                     end
                  end
                  ACT_DELETE_KEY: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        key_in      = req_data;
                        iss_off_in  = '0;
                        iss_slot_in = front_ff;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         // Read one entry a cycle and compare the entry read in the previous cycle
         ST_SCAN: begin
            if (matched) begin
               status_in = STATUS_OK;
               state_in  = ST_FINISH;
               if (cmp_off_ff == '0) begin
                  front_in = slot_next(front_ff);
                  count_in = last_off;
               end else if (cmp_off_ff == last_off) begin
                  count_in = last_off;
               end else begin
                  dst_off_in  = cmp_off_ff;
                  dst_slot_in = cmp_slot_ff;
                  iss_off_in  = CNT_W'(cmp_off_ff + 1'b1);
                  iss_slot_in = slot_next(cmp_slot_ff);
                  state_in    = ST_SHIFT;
               end
            end else if (cmp_vld_ff && (cmp_off_ff == last_off)) begin
               status_in = STATUS_NOKEY;
               state_in  = ST_FINISH;
            end else if (iss_off_ff < count_ff) begin
               rd_en       = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_off_in  = iss_off_ff;
               cmp_slot_in = iss_slot_ff;
               iss_off_in  = CNT_W'(iss_off_ff + 1'b1);
               iss_slot_in = slot_next(iss_slot_ff);
            end
         end

         // Move each later entry down one place: read ahead, write behind
         ST_SHIFT: begin
            if (cmp_vld_ff) begin
               wr_en       = 1'b1;
               wr_addr     = dst_slot_ff;
               wr_data     = rd_data_ff;
               dst_off_in  = CNT_W'(dst_off_ff + 1'b1);
               dst_slot_in = slot_next(dst_slot_ff);
            end
            if (cmp_vld_ff && (dst_off_ff == CNT_W'(count_ff - 2'd2))) begin
               count_in = last_off;
               state_in = ST_FINISH;
            end else if (iss_off_ff < count_ff) begin
               rd_en       = 1'b1;
               cmp_vld_in  = 1'b1;
               iss_off_in  = CNT_W'(iss_off_ff + 1'b1);
               iss_slot_in = slot_next(iss_slot_ff);
            end
         end

         // Load the result once the output register is free
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      key_ff        <= key_in;
      iss_off_ff    <= iss_off_in;
      iss_slot_ff   <= iss_slot_in;
      cmp_off_ff    <= cmp_off_in;
      cmp_slot_ff   <= cmp_slot_in;
      dst_off_ff    <= dst_off_in;
      dst_slot_ff   <= dst_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // Occupancy never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Front pointer stays inside the store
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= PTR_W'(CAPACITY - 1))
      else $error("front pointer outside store");

   // An accepted item keeps the sequencer busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after accepting an item");

   // Close-up never writes the entry it reads in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("memory read and write hit the same entry");

   // Count moves by at most one per item
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != count_in) |->
         ((count_in == CNT_W'(count_ff + 1'b1)) || (count_in == last_off)))
      else $error("entry count jumped");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the bounded deque with delete by key. A directed
// table covers empty, full, absent keys, spare action codes and removals at
// the front, middle and back; random items follow. A shadow list predicts
// status and occupancy for every accepted item, and each result is checked
// in order against it, or against the status and occupancy a row types in.
// ============================================================================
module testbench;
   import bldq_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   localparam int OCC_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LIMIT    = 300000;

   // Action codes with no operation behind them
   localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } result_type;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      int                  times;
      bit                  typed;
      status_type          status;
      logic [OCC_W-1:0]    occupancy;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [ACTION_W-1:0]         req_action = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [OCC_W-1:0]            rsp_occupancy;

   // Shadow copy of the list
   logic [VALUE_W-1:0] list_store [CAPACITY];
   logic [IDX_W-1:0]   list_front = '0;
   logic [OCC_W-1:0]   list_count = '0;

   result_type awaited_results [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      fill_bias = 1'b1;

   // Directed items; status and occupancy typed in only where obvious
   stim_row_type directed_rows [24] = '{
      '{ACT_POP_FRONT,  32'h0000_0000, 1,  1'b1, STATUS_EMPTY, 5'd0},
      '{ACT_POP_BACK,   32'h0000_0000, 1,  1'b1, STATUS_EMPTY, 5'd0},
      '{ACT_DELETE_KEY, 32'h0000_0000, 1,  1'b1, STATUS_EMPTY, 5'd0},
      '{ACT_SPARE_5,    32'hFFFF_FFFF, 1,  1'b1, STATUS_OK,    5'd0},
      '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, STATUS_OK,    5'd1},
      '{ACT_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, STATUS_OK,    5'd2},
      '{ACT_DELETE_KEY, 32'h0000_0000, 1,  1'b1, STATUS_NOKEY, 5'd2},
      '{ACT_DELETE_KEY, 32'h8000_0000, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_FRONT, 32'h0000_0000, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_FRONT, 32'h5555_5555, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_BACK,  32'hAAAA_AAAA, 12, 1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_FRONT, 32'h0000_0001, 1,  1'b1, STATUS_FULL,  5'd16},
      '{ACT_PUSH_BACK,  32'h0000_0001, 1,  1'b1, STATUS_FULL,  5'd16},
      '{ACT_DELETE_KEY, 32'hAAAA_AAAA, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_DELETE_KEY, 32'h5555_5555, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_SPARE_6,    32'h1234_5678, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_SPARE_7,    32'h8765_4321, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_PUSH_BACK,  32'h1234_5678, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_DELETE_KEY, 32'h1234_5678, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_DELETE_KEY, 32'h7FFF_FFFF, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_DELETE_KEY, 32'h8000_0000, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_POP_FRONT,  32'h0000_0000, 1,  1'b0, STATUS_OK,    5'd0},
      '{ACT_POP_BACK,   32'h0000_0000, 3,  1'b0, STATUS_OK,    5'd0}
   };

   bounded_list_deque_with_key_delete_unit #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DEFAULT_DATA_WIDTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow list and return its result
   function automatic result_type apply_to_shadow_list(input logic [ACTION_W-1:0] act,
                                                       input logic [VALUE_W-1:0] val);
      result_type res;
      int      hit;
      res.status = STATUS_OK;
      case (act)
         ACT_PUSH_FRONT: begin
            if (list_count == CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               list_front = list_front - 1'b1;
               list_store[list_front] = val;
               list_count = list_count + 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (list_count == CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               list_store[list_front + IDX_W'(list_count)] = val;
               list_count = list_count + 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (list_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               list_front = list_front + 1'b1;
               list_count = list_count - 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (list_count == 0) res.status = STATUS_EMPTY;
            else list_count = list_count - 1'b1;
         end
         ACT_DELETE_KEY: begin
            hit = -1;
            for (int i = 0; i < int'(list_count); i++) begin
               if (hit < 0 && list_store[list_front + IDX_W'(i)] == val) hit = i;
            end
            if (list_count == 0) begin
               res.status = STATUS_EMPTY;
            end else if (hit < 0) begin
               res.status = STATUS_NOKEY;
            end else if (hit == 0) begin
               list_front = list_front + 1'b1;
               list_count = list_count - 1'b1;
            end else begin
               // close up the entries behind the removed one
               for (int j = hit; j + 1 < int'(list_count); j++) begin
                  list_store[list_front + IDX_W'(j)] = list_store[list_front + IDX_W'(j + 1)];
               end
               list_count = list_count - 1'b1;
            end
         end
         default: ;
      endcase
      res.occupancy = list_count;
      return res;
   endfunction

   // Offer one item, hold it until taken, then record what it should return
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                            input bit typed, input result_type typed_res);
      bit      taken;
      result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end
      res = apply_to_shadow_list(act, val);
      awaited_results.push_back(typed ? typed_res : res);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return VALUE_W'(int'($urandom_range(7)) - 3);
         5, 6, 7:       return $urandom;
         8:             return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      endcase
   endfunction

   // Mostly keys that are held, so removals land at every position
   function automatic logic [VALUE_W-1:0] pick_key();
      if (list_count != 0 && $urandom_range(99) < 70)
         return list_store[list_front + IDX_W'($urandom_range(int'(list_count) - 1))];
      return pick_value();
   endfunction

   // Lean toward pushes or removals so the list swings between empty and full
   function automatic logic [ACTION_W-1:0] pick_action();
      int r;
      r = $urandom_range(99);
      if (fill_bias) begin
         if (r < 35) return ACT_PUSH_FRONT;
         if (r < 70) return ACT_PUSH_BACK;
         if (r < 78) return ACT_POP_FRONT;
         if (r < 84) return ACT_POP_BACK;
         if (r < 97) return ACT_DELETE_KEY;
      end else begin
         if (r < 14) return ACT_PUSH_FRONT;
         if (r < 28) return ACT_PUSH_BACK;
         if (r < 50) return ACT_POP_FRONT;
         if (r < 72) return ACT_POP_BACK;
         if (r < 97) return ACT_DELETE_KEY;
      end
      return 3'(5 + $urandom_range(2));
   endfunction

   task automatic run_random(input int n_items);
      logic [ACTION_W-1:0] act;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(29) == 0) fill_bias = ~fill_bias;
         act = pick_action();
         send_item(act, (act == ACT_DELETE_KEY) ? pick_key() : pick_value(), 1'b0, '0);
      end
   endtask

   // Random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check each result taken at the coming edge against the oldest prediction
   always @(negedge clock) begin
      result_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_results.size() == 0) begin
            $display("%0t unexpected result: status %0d occupancy %0d",
                     $time, rsp_status, rsp_occupancy);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t occupancy mismatch: expected %0d, actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      result_type typed_res;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sender rarely idles, receiver mostly stalls
      send_idle_pct = 6;
      recv_idle_pct = 76;
      foreach (directed_rows[r]) begin
         typed_res.status    = directed_rows[r].status;
         typed_res.occupancy = directed_rows[r].occupancy;
         repeat (directed_rows[r].times) begin
            send_item(directed_rows[r].action, directed_rows[r].value,
                      directed_rows[r].typed, typed_res);
         end
      end
      drain_results();
      run_random(150);
      drain_results();

      // Sender mostly idles, receiver rarely stalls
      send_idle_pct = 76;
      recv_idle_pct = 6;
      run_random(150);
      drain_results();

      // Back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150);
      drain_results();

      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
